@@ hw/rtl/psg_pkg.sv @@
// Package for the programmable sound generator: shared types, constants and tables.
// Used by psg_ctrl, psg_dp and programmable_sound_generator; depends on nothing.
package psg_pkg;

    localparam int NCH = 4;
    localparam int CNT_W = 20;
    localparam int EDGE_ONE = 32768;
    localparam logic [15:0] NOISE_SEED = 16'h8000;
    localparam logic [7:0] RATE_FOLLOW = 8'h80;
    localparam logic [2:0] REG_NOISE = 3'd6;

    localparam logic [2:0] CFG_ENABLE = 3'd0;
    localparam logic [2:0] CFG_VOLSEL = 3'd1;
    localparam logic [2:0] CFG_TAPS = 3'd2;
    localparam logic [2:0] CFG_WIDTH = 3'd3;
    localparam logic [2:0] CFG_BOOST = 3'd4;
    localparam logic [2:0] CFG_STEP = 3'd5;

    typedef struct packed {
        logic write;
        logic mix_clear;
        logic mix_add;
        logic advance;
        logic tone_update;
        logic div_start;
        logic edge_start;
        logic noise_update;
        logic [1:0] ch;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic edge_done;
    } t_status;

    function automatic logic [10:0] vol_lookup(input logic sel, input logic [3:0] v);
        logic [10:0] r;
        begin
            r = 11'd0;
            if (sel) begin
                case (v)
                    4'd0: r = 11'd1516; 4'd1: r = 11'd1205; 4'd2: r = 11'd957;
                    4'd3: r = 11'd760;  4'd4: r = 11'd603;  4'd5: r = 11'd479;
                    4'd6: r = 11'd381;  4'd7: r = 11'd303;  4'd8: r = 11'd240;
                    4'd9: r = 11'd191;  4'd10: r = 11'd152; 4'd11: r = 11'd120;
                    4'd12: r = 11'd96;  4'd13: r = 11'd76;  4'd14: r = 11'd60;
                    default: r = 11'd0;
                endcase
            end else begin
                case (v)
                    4'd0, 4'd1, 4'd2: r = 11'd892;
                    4'd3: r = 11'd760;  4'd4: r = 11'd623;  4'd5: r = 11'd497;
                    4'd6: r = 11'd404;  4'd7: r = 11'd323;  4'd8: r = 11'd257;
                    4'd9: r = 11'd198;  4'd10: r = 11'd159; 4'd11: r = 11'd123;
                    4'd12: r = 11'd96;  4'd13: r = 11'd75;  4'd14: r = 11'd60;
                    default: r = 11'd0;
                endcase
            end
            return r;
        end
    endfunction

endpackage

@@ hw/rtl/psg_div.sv @@
// Unsigned restoring divider, one quotient bit per cycle.
// Uses no package; instantiated by psg_dp.
module psg_div #(
    parameter int NW = 48,
    parameter int DW = 42
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_q, n_q;
    logic [DW:0]   r_rem, n_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy, r_done, n_done;
    logic [DW:0]   w_try;

    always_comb begin
        n_q = r_q;
        n_rem = r_rem;
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_try = {r_rem[DW-1:0], r_q[NW-1]};
        if (i_start) begin
            n_q = i_num;
            n_rem = '0;
            n_cnt = CW'(NW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_try >= {1'b0, r_den}) begin
                n_rem = w_try - {1'b0, r_den};
                n_q = {r_q[NW-2:0], 1'b1};
            end else begin
                n_rem = w_try;
                n_q = {r_q[NW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
        r_q <= n_q;
        r_rem <= n_rem;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

@@ hw/rtl/psg_dp.sv @@
// Datapath of the sound generator: registers, channel state, mixer, edge fraction.
// Depends on psg_pkg and psg_div.
module psg_dp
    import psg_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    input  logic [7:0]          i_data,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [23:0]         i_cfg_data,
    output logic signed [15:0]  o_sample
);
    localparam int FB = FRACTION_BITS;
    localparam int NB = 24 - FB + 1;
    localparam int EW = CNT_W + FB + 3;
    localparam int NUMW = EW + 16;

    logic [3:0]  r_en;
    logic        r_vsel, r_boost;
    logic [15:0] r_taps;
    logic [4:0]  r_nwid;
    logic [23:0] r_step;

    logic [9:0]  r_per [3];
    logic [3:0]  r_vol [NCH];
    logic [2:0]  r_nctl;
    logic [2:0]  r_lidx;
    logic [7:0]  r_rate;
    logic signed [CNT_W-1:0] r_cnt [NCH];
    logic [NCH-1:0] r_pol;
    logic signed [17:0] r_edge [3];
    logic [2:0]  r_evld;
    logic [15:0] r_shift;
    logic [FB-1:0] r_cfrac;
    logic [NB-1:0] r_n;
    logic signed [17:0] r_mix;
    logic signed [15:0] r_out;

    logic [1:0]  w_ch;
    logic [10:0] w_amp;
    logic signed [29:0] w_prod;
    logic signed [17:0] w_term;
    logic [24:0] w_acc;
    logic [9:0]  w_per;
    logic [NB+10:0] w_skip;
    logic [NB:0]    w_qt;
    logic [9:0]  w_divisor;
    logic        w_fb;
    logic [4:0]  w_w;
    logic [15:0] w_nshift;

    // Edge fraction divider and the quotient divider for counter reload.
    logic signed [EW-1:0] r_num, r_den;
    logic [NUMW-1:0] w_dquot;
    logic w_ddone;
    logic [NUMW-1:0] w_absnum;
    logic [EW-1:0] w_den_e;
    logic w_neg;
    logic signed [17:0] w_fclamp;

    logic [NB-1:0] r_qn;
    logic [9:0]  r_qd;
    logic [NB-1:0] r_qq;
    logic [9:0]  r_qr;
    logic [4:0]  r_qc;
    logic        r_qbusy;
    logic [10:0] w_qtry;

    assign w_ch = i_cmd.ch;
    assign w_amp = r_en[w_ch] ? vol_lookup(r_vsel, r_vol[w_ch]) : 11'd0;
    assign w_prod = $signed({1'b0, w_amp}) * r_edge[w_ch[1:0] == 2'd3 ? 2'd0 : w_ch];
    assign w_acc = {{(25-FB){1'b0}}, r_cfrac} + {1'b0, r_step};

    always_comb begin
        w_term = '0;
        if (w_ch == 2'd3) begin
            w_term = (r_shift[0]) ? (r_boost ? 18'($unsigned({w_amp, 1'b0}))
                                                : 18'($unsigned(w_amp))) : 18'sd0;
        end else if (r_evld[w_ch]) begin
            w_term = 18'(w_prod / 30'sd32768);
        end else begin
            w_term = r_pol[w_ch] ? 18'($unsigned(w_amp)) : -18'($signed({7'd0, w_amp}));
        end
    end

    assign w_per = (w_ch == 2'd3) ? 10'd0 : r_per[w_ch];
    assign w_divisor = (w_ch == 2'd3) ? {2'b0, (r_rate == 8'd0 ? 8'h10 : r_rate)}
                                      : (w_per == 10'd0 ? 10'd1 : w_per);

    // Quotient unit: n / divisor, one bit per cycle, started with div_start.
    assign w_qtry = {r_qr[9:0], r_qq[NB-1]};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qbusy <= 1'b0;
            r_qc <= '0;
        end else begin
            if (i_cmd.div_start) begin
                r_qbusy <= 1'b1;
                r_qc <= 5'(NB);
            end else if (r_qbusy) begin
                r_qc <= r_qc - 1'b1;
                if (r_qc == 5'd1) begin
                    r_qbusy <= 1'b0;
                end
            end
        end
        if (i_cmd.div_start) begin
            r_qq <= r_n;
            r_qr <= '0;
            r_qd <= w_divisor;
        end else if (r_qbusy) begin
            if ({1'b0, w_qtry} >= {2'b0, r_qd}) begin
                r_qr <= 10'(w_qtry - {1'b0, r_qd});
                r_qq <= {r_qq[NB-2:0], 1'b1};
            end else begin
                r_qr <= 10'(w_qtry);
                r_qq <= {r_qq[NB-2:0], 1'b0};
            end
        end
    end
    assign w_qt = {1'b0, r_qq} + 1'b1;
    assign w_skip = (NB+11)'(w_qt) * (NB+11)'(r_qd);

    // Edge numerator and denominator from the counter value after decrement.
    logic signed [EW-1:0] w_nume, w_dene;
    always_comb begin
        w_nume = ($signed({{(EW-NB-FB){1'b0}}, r_n, {FB{1'b0}}}))
               - $signed({{(EW-FB){1'b0}}, r_cfrac})
               + ($signed(EW'(r_cnt[w_ch])) <<< (FB + 1));
        w_dene = $signed({{(EW-NB-FB){1'b0}}, r_n, {FB{1'b0}}})
               + $signed({{(EW-FB){1'b0}}, r_cfrac});
    end
    assign w_neg = r_num[EW-1];
    assign w_absnum = NUMW'(w_nume[EW-1] ? -w_nume : w_nume) << 15;
    assign w_den_e = w_dene;

    psg_div #(.NW(NUMW), .DW(EW)) u_div (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.edge_start),
        .i_num(w_absnum),
        .i_den(w_den_e),
        .o_done(w_ddone),
        .o_quot(w_dquot)
    );

    always_comb begin
        if (r_den == '0) begin
            w_fclamp = '0;
        end else if (w_dquot > NUMW'(EDGE_ONE)) begin
            w_fclamp = w_neg ? -18'sd32768 : 18'sd32768;
        end else begin
            w_fclamp = w_neg ? -$signed({2'b0, w_dquot[15:0]}) : $signed({2'b0, w_dquot[15:0]});
        end
        if (!r_pol[w_ch]) begin
            w_fclamp = -w_fclamp;
        end
    end

    always_comb begin
        w_fb = r_nctl[2] ? ^(r_shift & r_taps) : r_shift[0];
        w_w = (r_nwid == 5'd0) ? 5'd1 : (r_nwid > 5'd16 ? 5'd16 : r_nwid);
        w_nshift = (r_shift >> 1) | (16'(w_fb) << (w_w - 5'd1));
    end

    logic [2:0] w_r;
    logic [9:0] w_newper;
    always_comb begin
        w_r = i_data[7] ? i_data[6:4] : r_lidx;
        w_newper = r_per[w_r[2:1] == 2'd3 ? 2'd0 : w_r[2:1]];
        if (i_data[7]) begin
            w_newper = {w_newper[9:4], i_data[3:0]};
        end else begin
            w_newper = {i_data[5:0], w_newper[3:0]};
        end
        if (w_newper == 10'd0) begin
            w_newper = 10'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= 4'd15; r_vsel <= 1'b1; r_taps <= 16'h0009; r_nwid <= 5'd16;
            r_boost <= 1'b0; r_step <= 24'd332468;
            for (int i = 0; i < 3; i++) begin
                r_per[i] <= 10'd1;
                r_edge[i] <= '0;
            end
            for (int i = 0; i < NCH; i++) begin
                r_vol[i] <= 4'd15;
                r_cnt[i] <= '0;
            end
            r_evld <= '0; r_pol <= '1; r_nctl <= 3'd1; r_lidx <= '0;
            r_rate <= 8'h10; r_shift <= NOISE_SEED; r_cfrac <= '0;
            r_n <= '0; r_mix <= '0; r_out <= '0; r_num <= '0; r_den <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ENABLE: r_en <= i_cfg_data[3:0];
                    CFG_VOLSEL: r_vsel <= i_cfg_data[0];
                    CFG_TAPS:   r_taps <= i_cfg_data[15:0];
                    CFG_WIDTH:  r_nwid <= i_cfg_data[4:0];
                    CFG_BOOST:  r_boost <= i_cfg_data[0];
                    CFG_STEP:   r_step <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.write) begin
                r_lidx <= w_r;
                if (w_r == REG_NOISE) begin
                    r_nctl <= i_data[2:0];
                    r_shift <= NOISE_SEED;
                    r_rate <= 8'h10 << i_data[1:0];
                end else if (w_r[0]) begin
                    r_vol[w_r[2:1]] <= i_data[3:0];
                end else begin
                    if (w_r[2:1] != 2'd3) begin
                        r_per[w_r[2:1]] <= w_newper;
                    end
                end
            end
            if (i_cmd.mix_clear) begin
                r_mix <= '0;
            end
            if (i_cmd.mix_add) begin
                r_mix <= r_mix + w_term;
            end
            if (i_cmd.advance) begin
                r_n <= w_acc[24:FB];
                r_cfrac <= w_acc[FB-1:0];
                for (int i = 0; i < 3; i++) begin
                    r_cnt[i] <= r_cnt[i] - $signed({{(CNT_W-NB){1'b0}}, w_acc[24:FB]});
                end
                if (r_rate == RATE_FOLLOW) begin
                    r_cnt[3] <= r_cnt[2] - $signed({{(CNT_W-NB){1'b0}}, w_acc[24:FB]});
                end else begin
                    r_cnt[3] <= r_cnt[3] - $signed({{(CNT_W-NB){1'b0}}, w_acc[24:FB]});
                end
            end
            if (i_cmd.div_start) begin
                r_num <= w_nume;
                r_den <= w_dene;
            end
            if (i_cmd.tone_update) begin
                if (r_cnt[w_ch] <= 0) begin
                    r_cnt[w_ch] <= r_cnt[w_ch] + $signed(CNT_W'(w_skip));
                    if (w_divisor > 10'd1) begin
                        r_edge[w_ch] <= w_fclamp;
                        r_evld[w_ch] <= 1'b1;
                        r_pol[w_ch] <= ~r_pol[w_ch];
                    end else begin
                        r_pol[w_ch] <= 1'b1;
                        r_evld[w_ch] <= 1'b0;
                    end
                end else begin
                    r_evld[w_ch] <= 1'b0;
                end
            end
            if (i_cmd.noise_update && r_cnt[3] <= 0) begin
                r_pol[3] <= ~r_pol[3];
                if (r_rate != RATE_FOLLOW) begin
                    r_cnt[3] <= r_cnt[3] + $signed(CNT_W'(w_skip));
                end
                if (!r_pol[3]) begin
                    r_shift <= w_nshift;
                end
            end
            if (i_cmd.out_load) begin
                r_out <= r_mix[15:0];
            end
        end
    end

    assign o_status.edge_done = w_ddone;
    assign o_sample = r_out;
endmodule

@@ hw/rtl/psg_ctrl.sv @@
// Sequencer of the sound generator: handshakes and per-channel step order.
// Depends on psg_pkg.
module psg_ctrl
    import psg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  logic    i_func,
    output logic    o_valid,
    input  logic    i_ready,
    output t_cmd    o_cmd,
    input  t_status i_status
);
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MIX  = 8'b0000_0010,
        S_ADV  = 8'b0000_0100,
        S_QDIV = 8'b0000_1000,
        S_EDIV = 8'b0001_0000,
        S_UPD  = 8'b0010_0000,
        S_OUT  = 8'b0100_0000,
        S_HOLD = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [1:0] r_ch, n_ch;
    logic r_ovld, n_ovld;
    logic w_acc;

    assign o_ready = (r_state == S_IDLE);
    assign w_acc = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        n_ch = r_ch;
        n_ovld = r_ovld && !i_ready;
        o_cmd = '0;
        o_cmd.ch = r_ch;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_func) begin
                        o_cmd.mix_clear = 1'b1;
                        n_ch = 2'd0;
                        n_state = S_MIX;
                    end else begin
                        o_cmd.write = 1'b1;
                    end
                end
            end
            S_MIX: begin
                o_cmd.mix_add = 1'b1;
                n_ch = r_ch + 2'd1;
                if (r_ch == 2'd3) begin
                    n_state = S_ADV;
                end
            end
            S_ADV: begin
                o_cmd.advance = 1'b1;
                n_ch = 2'd0;
                n_state = S_QDIV;
            end
            S_QDIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.edge_start = 1'b1;
                n_state = S_EDIV;
            end
            S_EDIV: begin
                if (i_status.edge_done) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (r_ch == 2'd3) begin
                    o_cmd.noise_update = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_cmd.tone_update = 1'b1;
                    n_ch = r_ch + 2'd1;
                    n_state = S_QDIV;
                end
            end
            S_OUT: begin
                if (!r_ovld || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_ovld = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_HOLD: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ch <= '0;
            r_ovld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ch <= n_ch;
            r_ovld <= n_ovld;
        end
    end

    assign o_valid = r_ovld;
endmodule

@@ hw/rtl/programmable_sound_generator.sv @@
// Top level of the three-tone, one-noise sound generator.
// Depends on psg_pkg, psg_ctrl and psg_dp.
//
// Items enter on the input channel (i_valid/o_ready) with i_func and i_data.
// A write item (func 0) updates the sound registers as it is accepted.
// A tick item (func 1) produces one signed sample on o_sample (o_valid/i_ready).
// A tick mixes the channels, advances the counters, then runs the bit-serial
// edge-fraction divider once per channel in turn and loads the output register;
// o_ready returns in the same cycle as o_valid is set.
// One item is worked on at a time; the finished sample sits in an output
// register, so a stalled receiver only holds the next tick at its end.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at once
// and are to be made while the block is idle.
// Reset restores the sound registers and channel state; divider working registers are not reset.
module programmable_sound_generator
    import psg_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_func,
    input  logic [7:0]         i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_sample,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [23:0]        i_cfg_data
);
    t_cmd    w_cmd;
    t_status w_status;

    psg_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_func(i_func), .o_valid(o_valid), .i_ready(i_ready),
        .o_cmd(w_cmd), .i_status(w_status)
    );

    psg_dp #(.FRACTION_BITS(FRACTION_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_status(w_status),
        .i_data(i_data), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .o_sample(o_sample)
    );
endmodule
